// ===== hw/rtl/cshash_pkg.sv =====
// shared types and constants for the channel subscriber hash table
package cshash_pkg;

    localparam int TableSlotsDefault      = 32;
    localparam int SubscriberSlotsDefault = 8;

    localparam int ActionWidth  = 3;
    localparam int ChannelWidth = 16;
    localparam int HandleWidth  = 32;
    localparam int SubWidth     = 16;
    localparam int StatusWidth  = 3;
    localparam int SlotOutWidth = 5;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_LOOKUP = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_NOTIFY = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_NOTFOUND = 3'd1,
        STS_FULL     = 3'd2,
        STS_SUBFULL  = 3'd3,
        STS_NONE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input transaction, start probe at home slot
        logic rd_slot;    // read slot memories at probe index
        logic step;       // advance probe index
        logic do_insert;  // write slot at probe index as new producer
        logic do_add;     // write subscriber at free subscriber slot
        logic do_delete;  // mark slot deleted
        logic sub_rd;     // read subscriber id at sub index
        logic sub_step;   // advance sub index
        logic sub_clr;    // restart sub index at zero
        logic out_load;   // load output register
        logic [2:0] out_status;
        logic out_zero;   // clear slot, handle and subscriber fields
        logic out_use_in; // handle from input rather than stored
        logic out_sub_in; // subscriber from input
        logic out_sub_rd; // subscriber from id memory
        logic out_last;
    } cshash_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic       st_empty;
        logic       st_used;
        logic       match;
        logic       probe_done;  // visited every slot
        logic       sub_free;    // some subscriber slot is free
        logic       sub_any;     // at least one subscriber valid
        logic       sub_cur;     // current sub index is valid
        logic       sub_more;    // a valid subscriber lies past current index
    } cshash_sts_t;

endpackage

// ===== hw/rtl/cshash_datapath.sv =====
// datapath: slot memories, probe and subscriber counters, output register
module cshash_datapath #(
    parameter int TABLE_SLOTS      = cshash_pkg::TableSlotsDefault,
    parameter int SUBSCRIBER_SLOTS = cshash_pkg::SubscriberSlotsDefault
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [cshash_pkg::ActionWidth-1:0]    in_action,
    input  logic [cshash_pkg::ChannelWidth-1:0]   in_channel,
    input  logic [cshash_pkg::HandleWidth-1:0]    in_handle,
    input  logic [cshash_pkg::SubWidth-1:0]       in_sub,
    input  cshash_pkg::cshash_cmd_t               cmd,
    output cshash_pkg::cshash_sts_t               sts,
    output logic [cshash_pkg::StatusWidth-1:0]    out_status,
    output logic [cshash_pkg::SlotOutWidth-1:0]   out_slot,
    output logic [cshash_pkg::HandleWidth-1:0]    out_handle,
    output logic [cshash_pkg::SubWidth-1:0]       out_sub,
    output logic                                  out_last
);
    import cshash_pkg::*;

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SW = (SUBSCRIBER_SLOTS > 1) ? $clog2(SUBSCRIBER_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int MW = IW + SW;

    // status bits in flip-flops, reset clears
    logic [1:0] status_reg [TABLE_SLOTS];
    // payload memories
    logic [ChannelWidth-1:0]     chan_mem [TABLE_SLOTS];
    logic [HandleWidth-1:0]      hand_mem [TABLE_SLOTS];
    logic [SUBSCRIBER_SLOTS-1:0] valid_mem [TABLE_SLOTS];
    logic [SubWidth-1:0]         id_mem [TABLE_SLOTS*SUBSCRIBER_SLOTS];

    logic [ActionWidth-1:0]  act_reg;
    logic [ChannelWidth-1:0] chan_reg;
    logic [HandleWidth-1:0]  hand_reg;
    logic [SubWidth-1:0]     sub_reg;
    logic [IW-1:0]           idx_reg;
    logic [CW-1:0]           cnt_reg;
    logic [SW-1:0]           sidx_reg;
    logic [1:0]              rd_st_reg;
    logic [ChannelWidth-1:0] rd_chan_reg;
    logic [HandleWidth-1:0]  rd_hand_reg;
    logic [SUBSCRIBER_SLOTS-1:0] rd_valid_reg;
    logic [SubWidth-1:0]     rd_id_reg;
    logic [SW-1:0]           free_idx;
    logic                    free_any;
    logic [SUBSCRIBER_SLOTS-1:0] above_mask;
    logic [IW-1:0]           home;
    logic [MW-1:0]           wr_addr;
    logic [MW-1:0]           rd_addr;

    // home slot is channel modulo table size
    always_comb
    begin
        home = IW'(in_channel % TABLE_SLOTS);
    end

    // first free subscriber slot, lowest index
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int j = SUBSCRIBER_SLOTS - 1; j >= 0; j--)
        begin
            if (!rd_valid_reg[j])
            begin
                free_idx = SW'(j);
                free_any = 1'b1;
            end
        end
    end

    // valid subscribers above current index
    always_comb
    begin
        for (int j = 0; j < SUBSCRIBER_SLOTS; j++)
        begin
            above_mask[j] = rd_valid_reg[j] && (j > int'(sidx_reg));
        end
    end

    assign wr_addr = MW'(idx_reg * SUBSCRIBER_SLOTS + free_idx);
    assign rd_addr = MW'(idx_reg * SUBSCRIBER_SLOTS + sidx_reg);

    // input capture and counters
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= in_action;
            chan_reg <= in_channel;
            hand_reg <= in_handle;
            sub_reg  <= in_sub;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            cnt_reg  <= '0;
            sidx_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= home;
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= (int'(idx_reg) == TABLE_SLOTS - 1) ? '0 : idx_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.sub_clr)
                sidx_reg <= '0;
            else if (cmd.sub_step)
                sidx_reg <= sidx_reg + 1'b1;
        end
    end

    // slot status flip-flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                status_reg[i] <= SLOT_EMPTY;
        end
        else if (cmd.do_insert)
            status_reg[idx_reg] <= SLOT_USED;
        else if (cmd.do_delete)
            status_reg[idx_reg] <= SLOT_DELETED;
    end

    // slot memories, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.do_insert)
        begin
            chan_mem[idx_reg]  <= chan_reg;
            hand_mem[idx_reg]  <= hand_reg;
            valid_mem[idx_reg] <= '0;
        end
        else if (cmd.do_add)
            valid_mem[idx_reg] <= rd_valid_reg | (SUBSCRIBER_SLOTS'(1) << free_idx);
        if (cmd.rd_slot)
        begin
            rd_st_reg    <= status_reg[idx_reg];
            rd_chan_reg  <= chan_mem[idx_reg];
            rd_hand_reg  <= hand_mem[idx_reg];
            rd_valid_reg <= valid_mem[idx_reg];
        end
    end

    // subscriber id memory
    always_ff @(posedge clk)
    begin
        if (cmd.do_add)
            id_mem[wr_addr] <= sub_reg;
        if (cmd.sub_rd)
            rd_id_reg <= id_mem[rd_addr];
    end

    // status to controller
    always_comb
    begin
        sts.action     = act_reg;
        sts.st_empty   = (rd_st_reg == SLOT_EMPTY);
        sts.st_used    = (rd_st_reg == SLOT_USED);
        sts.match      = (rd_chan_reg == chan_reg);
        sts.probe_done = (int'(cnt_reg) >= TABLE_SLOTS - 1);
        sts.sub_free   = free_any;
        sts.sub_any    = |rd_valid_reg;
        sts.sub_cur    = rd_valid_reg[sidx_reg];
        sts.sub_more   = |above_mask;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status <= cmd.out_status;
            out_last   <= cmd.out_last;
            if (cmd.out_zero)
            begin
                out_slot   <= '0;
                out_handle <= '0;
                out_sub    <= '0;
            end
            else
            begin
                out_slot   <= SlotOutWidth'(idx_reg);
                out_handle <= cmd.out_use_in ? hand_reg : rd_hand_reg;
                out_sub    <= cmd.out_sub_in ? sub_reg :
                              (cmd.out_sub_rd ? rd_id_reg : '0);
            end
        end
    end

`ifndef SYNTHESIS
    a_one_write : assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_insert && (cmd.do_delete || cmd.do_add)))
        else $error("conflicting slot writes");
    a_load_home : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cnt_reg == '0))
        else $error("probe count not cleared");
    a_step_count : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && !cmd.load |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("probe count skipped");
`endif

endmodule

// ===== hw/rtl/cshash_ctrl.sv =====
// controller state machine for the channel subscriber hash table
module cshash_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  cshash_pkg::cshash_sts_t sts,
    output cshash_pkg::cshash_cmd_t cmd
);
    import cshash_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_WAIT, S_EVAL, S_SUBRD, S_SUBWAIT, S_SUBEMIT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   notify_more_reg, notify_more_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        notify_more_next = notify_more_reg;
        m_valid_next     = m_valid_reg;
        cmd              = '0;
        if (m_valid_reg && m_ready)
            m_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_valid && !m_valid_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // unknown actions give no result
                if (!(sts.action inside {ACT_INSERT, ACT_ADD, ACT_LOOKUP,
                                         ACT_DELETE, ACT_NOTIFY}))
                    state_next = S_IDLE;
                else
                begin
                    cmd.rd_slot = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.out_last = 1'b1;
                if (sts.action == ACT_INSERT)
                begin
                    if (!sts.st_used)
                    begin
                        cmd.do_insert  = 1'b1;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STS_OK;
                        cmd.out_use_in = 1'b1;
                        state_next     = S_OUT;
                    end
                    else if (sts.probe_done)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STS_FULL;
                        cmd.out_zero   = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = S_WAIT;
                    end
                end
                else if (sts.st_used && sts.match)
                begin
                    case (sts.action)
                        ACT_ADD:
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = S_OUT;
                            if (sts.sub_free)
                            begin
                                cmd.do_add     = 1'b1;
                                cmd.out_status = STS_OK;
                                cmd.out_sub_in = 1'b1;
                            end
                            else
                                cmd.out_status = STS_SUBFULL;
                        end
                        ACT_DELETE:
                        begin
                            cmd.do_delete  = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = STS_OK;
                            state_next     = S_OUT;
                        end
                        ACT_NOTIFY:
                        begin
                            if (!sts.sub_any)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = STS_NONE;
                                cmd.out_use_in = 1'b1;
                                state_next     = S_OUT;
                            end
                            else
                            begin
                                cmd.sub_clr = 1'b1;
                                state_next  = S_SUBRD;
                            end
                        end
                        default:
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = STS_OK;
                            state_next     = S_OUT;
                        end
                    endcase
                end
                else if (sts.st_empty || sts.probe_done)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = STS_NOTFOUND;
                    cmd.out_zero   = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = S_EVAL;
            end
            S_SUBRD:
            begin
                // skip invalid subscriber slots
                if (sts.sub_cur)
                begin
                    cmd.sub_rd       = 1'b1;
                    notify_more_next = sts.sub_more;
                    state_next       = S_SUBWAIT;
                end
                else
                    cmd.sub_step = 1'b1;
            end
            S_SUBWAIT:
            begin
                state_next = S_SUBEMIT;
            end
            S_SUBEMIT:
            begin
                if (!m_valid_reg || m_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = STS_OK;
                    cmd.out_use_in = 1'b1;
                    cmd.out_sub_rd = 1'b1;
                    cmd.out_last   = !notify_more_reg;
                    m_valid_next   = 1'b1;
                    if (notify_more_reg)
                    begin
                        cmd.sub_step = 1'b1;
                        state_next   = S_SUBRD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            notify_more_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            notify_more_reg <= notify_more_next;
            m_valid_reg     <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && (state_reg == S_SUBEMIT) |-> (!m_valid_reg || m_ready))
        else $error("output overwritten while pending");
    a_accept_idle : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !m_valid_reg)
        else $error("accepted with result pending");
    a_read_eval : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> $past(cmd.rd_slot))
        else $error("evaluated without slot read");
`endif

endmodule

// ===== hw/rtl/channel_subscriber_hash_table_top.sv =====
// top level of the channel subscriber hash table
// a hit at the home slot returns soonest; each extra probed slot adds a read and an
// evaluation, and linear probing covers up to TABLE_SLOTS slots in the worst case
// notify: one result per valid subscriber in subscriber slot order, skipping empty
// subscriber slots, or one none result if there is none; one transaction in flight,
// next input taken once the last result is handed off
// rst_n is asynchronous active low and marks every slot empty at once
module channel_subscriber_hash_table_top #(
    parameter int TABLE_SLOTS      = cshash_pkg::TableSlotsDefault,
    parameter int SUBSCRIBER_SLOTS = cshash_pkg::SubscriberSlotsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], channel[18:3], handle[50:19], subscriber[66:51]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], slot[7:3], handle_out[39:8], subscriber_out[55:40]
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import cshash_pkg::*;

    cshash_cmd_t cmd;
    cshash_sts_t sts;
    logic [StatusWidth-1:0]  o_status;
    logic [SlotOutWidth-1:0] o_slot;
    logic [HandleWidth-1:0]  o_handle;
    logic [SubWidth-1:0]     o_sub;

    cshash_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cshash_datapath #(
        .TABLE_SLOTS      (TABLE_SLOTS),
        .SUBSCRIBER_SLOTS (SUBSCRIBER_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_action  (s_axis_tdata[2:0]),
        .in_channel (s_axis_tdata[18:3]),
        .in_handle  (s_axis_tdata[50:19]),
        .in_sub     (s_axis_tdata[66:51]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (o_status),
        .out_slot   (o_slot),
        .out_handle (o_handle),
        .out_sub    (o_sub),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {o_sub, o_handle, o_slot, o_status};

endmodule

// ===== test/channel_subscriber_hash_table_top_tb.sv =====
// self-checking testbench for the channel subscriber hash table top level
`timescale 1ns / 100ps

module channel_subscriber_hash_table_top_tb;
    import cshash_pkg::*;

    localparam int NumSlots    = TableSlotsDefault;
    localparam int NumSubs     = SubscriberSlotsDefault;
    localparam int CycleLimit  = 1000000;
    localparam int DrainCycles = 200;
    localparam int RandPerPhase = 90;

    typedef struct packed {
        status_t     status;
        logic [4:0]  slot;
        logic [31:0] handle;
        logic [15:0] sub;
        logic        last;
    } notice_t;

    typedef struct {
        logic [2:0]  action;
        logic [15:0] channel;
        logic [31:0] handle;
        logic [15:0] sub;
        bit          typed;
        notice_t     notice;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    // shadow copy of the table
    slot_state_t tbl_state [NumSlots];
    logic [15:0] tbl_channel [NumSlots];
    logic [31:0] tbl_handle [NumSlots];
    logic [NumSubs-1:0] tbl_sub_valid [NumSlots];
    logic [15:0] tbl_sub_id [NumSlots][NumSubs];

    notice_t   pending_notices[$];
    request_t  directed_rows[$];
    logic [15:0] channel_pool [12];

    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    int notices_seen = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    channel_subscriber_hash_table_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 notices_seen);
        errors++;
    endtask

    // probe from the home slot; -1 when the channel is absent
    function automatic int locate_channel(input logic [15:0] ch);
        int idx;
        for (int i = 0; i < NumSlots; i++)
        begin
            idx = (ch + i) % NumSlots;
            if (tbl_state[idx] == SLOT_EMPTY)
                return -1;
            if (tbl_state[idx] == SLOT_USED && tbl_channel[idx] == ch)
                return idx;
        end
        return -1;
    endfunction

    function automatic notice_t make_notice(status_t st, int slot, logic [31:0] h,
                                            logic [15:0] sub, logic last);
        notice_t n;
        n.status = st;
        n.slot = slot[4:0];
        n.handle = h;
        n.sub = sub;
        n.last = last;
        return n;
    endfunction

    // apply one transaction to the shadow table and return its results
    task automatic apply_request(input request_t rq, output notice_t outs[$]);
        int s;
        int idx;
        int total;
        int n;
        bit done;
        outs = {};
        if (rq.action == ACT_INSERT)
        begin
            done = 0;
            for (int i = 0; i < NumSlots && !done; i++)
            begin
                idx = (rq.channel + i) % NumSlots;
                if (tbl_state[idx] != SLOT_USED)
                begin
                    tbl_state[idx] = SLOT_USED;
                    tbl_channel[idx] = rq.channel;
                    tbl_handle[idx] = rq.handle;
                    tbl_sub_valid[idx] = '0;
                    outs.push_back(make_notice(STS_OK, idx, rq.handle, 16'd0, 1'b1));
                    done = 1;
                end
            end
            if (!done)
                outs.push_back(make_notice(STS_FULL, 0, 32'd0, 16'd0, 1'b1));
            return;
        end
        if (rq.action > ACT_NOTIFY)
            return;
        s = locate_channel(rq.channel);
        if (s < 0)
        begin
            outs.push_back(make_notice(STS_NOTFOUND, 0, 32'd0, 16'd0, 1'b1));
            return;
        end
        case (rq.action)
            ACT_ADD:
            begin
                for (int j = 0; j < NumSubs; j++)
                begin
                    if (!tbl_sub_valid[s][j])
                    begin
                        tbl_sub_valid[s][j] = 1'b1;
                        tbl_sub_id[s][j] = rq.sub;
                        outs.push_back(make_notice(STS_OK, s, tbl_handle[s], rq.sub, 1'b1));
                        return;
                    end
                end
                outs.push_back(make_notice(STS_SUBFULL, s, tbl_handle[s], 16'd0, 1'b1));
            end
            ACT_LOOKUP:
                outs.push_back(make_notice(STS_OK, s, tbl_handle[s], 16'd0, 1'b1));
            ACT_DELETE:
            begin
                tbl_state[s] = SLOT_DELETED;
                outs.push_back(make_notice(STS_OK, s, tbl_handle[s], 16'd0, 1'b1));
            end
            default:
            begin
                total = $countones(tbl_sub_valid[s]);
                if (total == 0)
                    outs.push_back(make_notice(STS_NONE, s, rq.handle, 16'd0, 1'b1));
                n = 0;
                for (int j = 0; j < NumSubs; j++)
                begin
                    if (tbl_sub_valid[s][j])
                    begin
                        n++;
                        outs.push_back(make_notice(STS_OK, s, rq.handle, tbl_sub_id[s][j],
                                                   n == total));
                    end
                end
            end
        endcase
    endtask

    // drive one transaction and record what it should produce
    task automatic send_request(input request_t rq);
        notice_t outs[$];
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {5'd0, rq.sub, rq.handle, rq.channel, rq.action};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_request(rq, outs);
        if (rq.typed && outs.size() > 0)
            outs = '{rq.notice};
        foreach (outs[k])
            pending_notices.push_back(outs[k]);
        items_sent++;
    endtask

    function automatic request_t make_request(logic [2:0] act, logic [15:0] ch,
                                              logic [31:0] h, logic [15:0] sub);
        request_t rq;
        rq.action = act;
        rq.channel = ch;
        rq.handle = h;
        rq.sub = sub;
        rq.typed = 0;
        rq.notice = '0;
        return rq;
    endfunction

    task automatic add_row(logic [2:0] act, logic [15:0] ch, logic [31:0] h,
                           logic [15:0] sub);
        directed_rows.push_back(make_request(act, ch, h, sub));
    endtask

    task automatic add_typed_row(logic [2:0] act, logic [15:0] ch, logic [31:0] h,
                                 logic [15:0] sub, notice_t want);
        request_t rq;
        rq = make_request(act, ch, h, sub);
        rq.typed = 1;
        rq.notice = want;
        directed_rows.push_back(rq);
    endtask

    function automatic logic [15:0] pick_channel();
        if ($urandom_range(99) < 15)
            return 16'($urandom_range(16'hFFFF));
        return channel_pool[$urandom_range(11)];
    endfunction

    function automatic request_t random_request();
        int r;
        logic [2:0] act;
        r = $urandom_range(99);
        if (r < 25)
            act = ACT_INSERT;
        else if (r < 50)
            act = ACT_ADD;
        else if (r < 63)
            act = ACT_LOOKUP;
        else if (r < 82)
            act = ACT_DELETE;
        else if (r < 97)
            act = ACT_NOTIFY;
        else
            act = 3'($urandom_range(5, 7));
        return make_request(act, pick_channel(), $urandom, 16'($urandom_range(16'hFFFF)));
    endfunction

    // receiver stall pattern
    always @(negedge clk)
        m_axis_tready = ($urandom_range(99) >= snk_stall_pct);

    // result checker
    always @(posedge clk)
    begin
        notice_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            notices_seen++;
            if (pending_notices.size() == 0)
            begin
                $display("unexpected result %h last %b", m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = pending_notices.pop_front();
                if (m_axis_tdata[2:0] != want.status)
                    report_mismatch("status", m_axis_tdata[2:0], want.status);
                if (m_axis_tdata[7:3] != want.slot)
                    report_mismatch("slot", m_axis_tdata[7:3], want.slot);
                if (m_axis_tdata[39:8] != want.handle)
                    report_mismatch("handle", m_axis_tdata[39:8], want.handle);
                if (m_axis_tdata[55:40] != want.sub)
                    report_mismatch("subscriber", m_axis_tdata[55:40], want.sub);
                if (m_axis_tlast != want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
    end

    initial
    begin
        int homes[4];
        int idle_set[4];
        int stall_set[4];
        homes = '{0, 1, 31, 7};
        idle_set = '{0, 83, 0, 20};
        stall_set = '{0, 0, 83, 20};
        foreach (tbl_state[i])
        begin
            tbl_state[i] = SLOT_EMPTY;
            tbl_channel[i] = '0;
            tbl_handle[i] = '0;
            tbl_sub_valid[i] = '0;
            for (int j = 0; j < NumSubs; j++)
                tbl_sub_id[i][j] = '0;
        end
        foreach (channel_pool[i])
            channel_pool[i] = 16'(($urandom_range(16'hFFFF) & 16'hFFE0) | homes[i % 4]);

        // directed transactions: empty table, extremes, each action, not found, subscriber full and unknown actions
        add_typed_row(ACT_LOOKUP, 16'd0, 32'd0, 16'd0,
                      make_notice(STS_NOTFOUND, 0, 32'd0, 16'd0, 1'b1));
        add_typed_row(ACT_NOTIFY, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                      make_notice(STS_NOTFOUND, 0, 32'd0, 16'd0, 1'b1));
        add_typed_row(ACT_DELETE, 16'd5, 32'd0, 16'd0,
                      make_notice(STS_NOTFOUND, 0, 32'd0, 16'd0, 1'b1));
        add_typed_row(ACT_ADD, 16'd5, 32'd0, 16'hFFFF,
                      make_notice(STS_NOTFOUND, 0, 32'd0, 16'd0, 1'b1));
        add_typed_row(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'd0,
                      make_notice(STS_OK, 31, 32'hFFFF_FFFF, 16'd0, 1'b1));
        add_typed_row(ACT_LOOKUP, 16'hFFFF, 32'd0, 16'd0,
                      make_notice(STS_OK, 31, 32'hFFFF_FFFF, 16'd0, 1'b1));
        // home slot taken: wraps to slot 0
        add_row(ACT_INSERT, 16'd31, 32'h1234_5678, 16'd0);
        add_typed_row(ACT_NOTIFY, 16'hFFFF, 32'hA5A5_0001, 16'd0,
                      make_notice(STS_NONE, 31, 32'hA5A5_0001, 16'd0, 1'b1));
        for (int i = 0; i < NumSubs + 1; i++)
            add_row(ACT_ADD, 16'hFFFF, 32'd0, (i == 0) ? 16'hFFFF : 16'(i * 4099));
        add_row(ACT_NOTIFY, 16'hFFFF, 32'h0000_0000, 16'd0);
        add_row(ACT_DELETE, 16'hFFFF, 32'd0, 16'd0);
        // probe passes the deleted slot
        add_row(ACT_LOOKUP, 16'd31, 32'd0, 16'd0);
        add_row(ACT_INSERT, 16'd63, 32'h0BAD_F00D, 16'd0);
        add_row(3'd5, 16'd1, 32'd1, 16'd1);
        add_row(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_row(3'd7, 16'd0, 32'd0, 16'd0);
        add_row(ACT_NOTIFY, 16'd31, 32'hFFFF_FFFF, 16'd0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // fill the table to overflow, then delete entries of the pooled channels
        repeat (NumSlots + 2)
            send_request(make_request(ACT_INSERT, pick_channel(), $urandom, 16'd0));
        for (int i = 0; i < 44; i++)
            send_request(make_request(ACT_DELETE, channel_pool[i % 12], 32'd0, 16'd0));

        // random traffic under each idle pattern
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = idle_set[p];
            snk_stall_pct = stall_set[p];
            repeat (RandPerPhase)
                send_request(random_request());
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;

        while (pending_notices.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (pending_notices.size() != 0)
        begin
            $display("%0d results never arrived", pending_notices.size());
            errors++;
        end
        $display("sent %0d transactions (directed, table overflow, random under 4 idle mixes)",
                 items_sent);
        $display("checked %0d results, %0d mismatches", notices_seen, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
